FILE: rtl/aecg_pkg.sv
// Shared types and constants for the auto exposure and contrast gain block.
// Used by aecg_div and auto_exposure_contrast_gain; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package aecg_pkg;

  // Serial divider geometry
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Contrast scale formula: (325 * (c + 128) / (387 - c)) >> 5
  localparam int SCALE_MUL   = 325;
  localparam int SCALE_OFS   = 128;
  localparam int SCALE_DEN   = 387;
  localparam int SCALE_SHIFT = 5;
  localparam int SCALE_W     = 5;
  localparam int SCALE_NUM_W = 17;
  localparam int SCALE_DEN_W = 9;

  // Constant divisors handled by narrow serial lanes
  localparam int DIV_TEN  = 10;
  localparam int DIV_NINE = 9;

  // Color lanes: serial multiply by scale, then serial divide by ten
  localparam int LANE_W          = 21;
  localparam int LANES           = 4;
  localparam int COL_MULT_STEPS  = SCALE_W;
  localparam int COL_DIV_STEPS   = LANE_W;
  localparam int COL_CNT_W       = $clog2(COL_MULT_STEPS + COL_DIV_STEPS);
  localparam int OFFSET_SHIFT    = 7;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DIVISOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_AVERAGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_BAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CEILING    = 3'd4;

  // Reset values
  localparam logic [31:0] FRAME_DIVISOR_RESET   = 32'd4147200;
  localparam logic [9:0]  TARGET_AVERAGE_RESET  = 10'd100;
  localparam logic [7:0]  HYSTERESIS_BAND_RESET = 8'd4;
  localparam logic [6:0]  GAIN_FLOOR_RESET      = 7'd5;
  localparam logic [6:0]  GAIN_CEILING_RESET    = 7'd100;
  localparam logic [6:0]  GAIN_RESET            = 7'd80;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/aecg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle while busy.
// Depends on aecg_pkg for its width and status type.
`timescale 1ns / 1ps
`default_nettype none

module aecg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [aecg_pkg::DIV_W-1:0]    num,
  input  logic [aecg_pkg::DIV_W-1:0]    den,
  output logic [aecg_pkg::DIV_W-1:0]    quo,
  output aecg_pkg::div_status_t         status
);
  import aecg_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo_sh;
  logic [DIV_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_W:0]       shifted;
  logic                 fits;
  logic [DIV_W-1:0]     rem_next;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted  = {rem, quo_sh[DIV_W-1]};
    fits     = shifted >= {1'b0, den_q};
    rem_next = fits ? DIV_W'(shifted - {1'b0, den_q}) : shifted[DIV_W-1:0];
  end

  // Control: busy for one pass, done pulses once the quotient is complete
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(DIV_W - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DIV_CNT_W'(DIV_W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: shift numerator bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      quo_sh <= num;
      den_q  <= den;
      cnt    <= '0;
    end else if (busy) begin
      rem    <= rem_next;
      quo_sh <= {quo_sh[DIV_W-2:0], fits};
      cnt    <= cnt + 1'b1;
    end
  end

  assign quo         = quo_sh;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

FILE: rtl/auto_exposure_contrast_gain.sv
// Per-frame auto exposure and contrast constant block, top level.
// Depends on aecg_pkg and the serial divider aecg_div.
//
// Usage: one input word per video frame on in_valid/in_ready, one result
// word on out_valid/out_ready. Registers are written on cfg_valid/cfg_ready
// (ready whenever reset is low) with cfg_index 0..4; other indexes are dropped.
// A word takes three back-to-back passes through the bit-serial divider
// (contrast scale, camera one average, camera two average), and the next
// word is taken only after its result is loaded. The divide by nine of the
// frame divisor runs beside the first pass, and the color multiply /
// divide-by-ten lanes beside the second.
// The result sits in an output register; the next input word is taken
// while it waits. If the receiver stalls, a finished word waits in the last
// sequencer step until the output register frees, and no new input is
// taken meanwhile.
// Reset (synchronous, active high) restores register defaults, sets both
// camera gains to 80 and drops any word in flight.
`timescale 1ns / 1ps
`default_nettype none

module auto_exposure_contrast_gain (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    red_gain,
  input  logic [15:0]                    green_gain,
  input  logic [15:0]                    blue_gain,
  input  logic [7:0]                     contrast_level,
  input  logic [15:0]                    brightness_level,
  input  logic [31:0]                    pixel_sum_one,
  input  logic [31:0]                    pixel_sum_two,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [17:0]                    red_constant,
  output logic [17:0]                    green_constant,
  output logic [17:0]                    blue_constant,
  output logic signed [23:0]             offset_constant,
  output logic [6:0]                     sensor_gain_one,
  output logic [6:0]                     sensor_gain_two,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aecg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import aecg_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCALE  = 3'd1;
  localparam logic [2:0] S_AVG1   = 3'd2;
  localparam logic [2:0] S_AVG2   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  // Configuration registers
  logic [31:0] frame_divisor;
  logic [9:0]  target_average;
  logic [7:0]  hysteresis_band;
  logic [6:0]  gain_floor;
  logic [6:0]  gain_ceiling;

  // Camera gain state
  logic [6:0]  gain_one;
  logic [6:0]  gain_two;

  // Sequencer and captured word
  logic [2:0]  state;
  logic [15:0] gain_in [3];
  logic [15:0] bright_q;
  logic [31:0] sum_one_q;
  logic [31:0] sum_two_q;
  logic [31:0] avg_one;

  // Shared divider
  logic              div_start;
  logic [DIV_W-1:0]  div_num;
  logic [DIV_W-1:0]  div_den;
  logic [DIV_W-1:0]  div_quo;
  div_status_t       div_st;

  // Divide-by-nine lane for the camera two divisor
  logic [DIV_W-1:0]  q9_sh;
  logic [3:0]        rem9;
  logic [4:0]        trial9;
  logic              ge9;
  logic [3:0]        rem9_next;

  // Color lanes: three gains and the offset term
  logic [LANE_W-1:0]    gain_sh [3];
  logic [SCALE_W-1:0]   scale_sh;
  logic [LANE_W-1:0]    prod [LANES];
  logic [3:0]           rem10 [LANES];
  logic [4:0]           trial10 [LANES];
  logic                 ge10 [LANES];
  logic [3:0]           rem10_next [LANES];
  logic [COL_CNT_W-1:0] col_cnt;
  logic                 col_busy;

  logic                 accept;
  logic                 out_load;
  logic [SCALE_NUM_W-1:0] scale_num;
  logic [SCALE_DEN_W-1:0] scale_den;
  logic [SCALE_W-1:0]   scale_val;
  logic signed [16:0]   off_diff;
  logic [6:0]           gain_one_next;
  logic [6:0]           gain_two_next;

  // Step a gain by the hysteresis rule, then clamp floor first
  function automatic logic [6:0] next_gain(
    input logic [6:0]  g,
    input logic [31:0] avg,
    input logic [9:0]  tgt,
    input logic [7:0]  hb,
    input logic [6:0]  fl,
    input logic [6:0]  cl
  );
    logic signed [11:0] lo;
    logic [10:0]        hi;
    logic signed [8:0]  gs;
    logic               below;
    logic               above;
    logic [6:0]         res;
    lo    = $signed({2'b00, tgt}) - $signed({4'b0000, hb});
    hi    = {1'b0, tgt} + {3'b000, hb};
    below = !lo[11] && (avg < {21'b0, lo[10:0]});
    above = avg > {21'b0, hi};
    priority if (below) begin
      gs = $signed({2'b00, g}) + 9'sd1;
    end else if (above) begin
      gs = $signed({2'b00, g}) - 9'sd1;
    end else begin
      gs = $signed({2'b00, g});
    end
    priority if (gs < $signed({2'b00, fl})) begin
      res = fl;
    end else if (gs >= $signed({2'b00, cl})) begin
      res = cl;
    end else begin
      res = gs[6:0];
    end
    return res;
  endfunction

  assign in_ready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == S_FINISH) && (!out_valid || out_ready);
  assign scale_val = div_quo[SCALE_W+SCALE_SHIFT-1:SCALE_SHIFT];

  // Contrast scale operands
  assign scale_num = SCALE_NUM_W'(SCALE_MUL) * {9'b0, contrast_level}
                   + SCALE_NUM_W'(SCALE_MUL * SCALE_OFS);
  assign scale_den = SCALE_DEN_W'(SCALE_DEN) - {1'b0, contrast_level};

  // Pick divider operands for each pass
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      S_IDLE: begin
        div_start = accept;
        div_num   = {15'b0, scale_num};
        div_den   = {23'b0, scale_den};
      end
      S_SCALE: begin
        div_start = div_st.done;
        div_num   = sum_one_q;
        div_den   = frame_divisor;
      end
      S_AVG1: begin
        div_start = div_st.done;
        div_num   = sum_two_q;
        div_den   = q9_sh;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  aecg_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quo    (div_quo),
    .status (div_st)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (accept)      state <= S_SCALE;
        S_SCALE:  if (div_st.done) state <= S_AVG1;
        S_AVG1:   if (div_st.done) state <= S_AVG2;
        S_AVG2:   if (div_st.done) state <= S_FINISH;
        S_FINISH: if (out_load)    state <= S_IDLE;
        default:                   state <= S_IDLE;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (accept) begin
      gain_in[0] <= red_gain;
      gain_in[1] <= green_gain;
      gain_in[2] <= blue_gain;
      bright_q   <= brightness_level;
      sum_one_q  <= pixel_sum_one;
      sum_two_q  <= pixel_sum_two;
    end
    if ((state == S_AVG1) && div_st.done) begin
      avg_one <= div_quo;
    end
  end

  // Divide the frame divisor by nine, one bit per cycle beside the scale pass
  always_comb begin
    trial9    = {rem9, q9_sh[DIV_W-1]};
    ge9       = trial9 >= 5'(DIV_NINE);
    rem9_next = ge9 ? 4'(trial9 - 5'(DIV_NINE)) : trial9[3:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q9_sh <= frame_divisor;
      rem9  <= '0;
    end else if ((state == S_SCALE) && div_st.busy) begin
      q9_sh <= {q9_sh[DIV_W-2:0], ge9};
      rem9  <= rem9_next;
    end
  end

  // Divide-by-ten trial for each lane
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial10[i]    = {rem10[i], prod[i][LANE_W-1]};
      ge10[i]       = trial10[i] >= 5'(DIV_TEN);
      rem10_next[i] = ge10[i] ? 4'(trial10[i] - 5'(DIV_TEN)) : trial10[i][3:0];
    end
  end

  // Color lanes: shift-add multiply by scale, then serial divide by ten
  always_ff @(posedge clk) begin
    if (rst) begin
      col_busy <= 1'b0;
    end else if ((state == S_SCALE) && div_st.done) begin
      col_busy <= 1'b1;
    end else if (col_busy &&
                 (col_cnt == COL_CNT_W'(COL_MULT_STEPS + COL_DIV_STEPS - 1))) begin
      col_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SCALE) && div_st.done) begin
      col_cnt  <= '0;
      scale_sh <= scale_val;
      for (int i = 0; i < 3; i++) begin
        gain_sh[i] <= {5'b0, gain_in[i]};
        prod[i]    <= '0;
        rem10[i]   <= '0;
      end
      prod[3]  <= LANE_W'({scale_val, OFFSET_SHIFT'(0)});
      rem10[3] <= '0;
    end else if (col_busy) begin
      col_cnt <= col_cnt + 1'b1;
      if (col_cnt < COL_CNT_W'(COL_MULT_STEPS)) begin
        // add the shifted gain where the scale bit is set
        scale_sh <= scale_sh >> 1;
        for (int i = 0; i < 3; i++) begin
          if (scale_sh[0]) begin
            prod[i] <= prod[i] + gain_sh[i];
          end
          gain_sh[i] <= gain_sh[i] << 1;
        end
      end else begin
        for (int i = 0; i < LANES; i++) begin
          prod[i]  <= {prod[i][LANE_W-2:0], ge10[i]};
          rem10[i] <= rem10_next[i];
        end
      end
    end
  end

  // Offset and gain updates
  assign off_diff      = $signed({1'b0, bright_q}) - $signed({8'b0, prod[3][8:0]});
  assign gain_one_next = next_gain(gain_one, avg_one, target_average, hysteresis_band,
                                   gain_floor, gain_ceiling);
  assign gain_two_next = next_gain(gain_two, div_quo, target_average, hysteresis_band,
                                   gain_floor, gain_ceiling);

  // Gain state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_one  <= GAIN_RESET;
      gain_two  <= GAIN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        gain_one  <= gain_one_next;
        gain_two  <= gain_two_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      red_constant    <= prod[0][17:0];
      green_constant  <= prod[1][17:0];
      blue_constant   <= prod[2][17:0];
      offset_constant <= {off_diff, OFFSET_SHIFT'(0)};
      sensor_gain_one <= gain_one_next;
      sensor_gain_two <= gain_two_next;
    end
  end

  // Configuration writes, masked to register width
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_divisor   <= FRAME_DIVISOR_RESET;
      target_average  <= TARGET_AVERAGE_RESET;
      hysteresis_band <= HYSTERESIS_BAND_RESET;
      gain_floor      <= GAIN_FLOOR_RESET;
      gain_ceiling    <= GAIN_CEILING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_DIVISOR:   frame_divisor   <= cfg_data;
        REG_TARGET_AVERAGE:  target_average  <= cfg_data[9:0];
        REG_HYSTERESIS_BAND: hysteresis_band <= cfg_data[7:0];
        REG_GAIN_FLOOR:      gain_floor      <= cfg_data[6:0];
        REG_GAIN_CEILING:    gain_ceiling    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Divider finishes only inside one of its three passes
  a_div_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_SCALE || state == S_AVG1 || state == S_AVG2))
    else $error("divider done outside a divide pass");

  // Color lanes are finished before the camera two pass starts
  a_lanes_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_AVG1 && div_st.done) |-> !col_busy)
    else $error("color lanes still busy at end of camera one pass");

  // Accepting a word starts the divider on the next cycle
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> (div_st.busy && state == S_SCALE))
    else $error("accepted word did not start the scale pass");

  // Gain state moves only when a result is loaded
  a_gain_hold: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> ($stable(gain_one) && $stable(gain_two)))
    else $error("camera gain changed without a result");

  // A finished word waits while the output register is occupied
  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !out_ready) |=> (state == S_FINISH))
    else $error("finished word dropped while output stalled");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for auto_exposure_contrast_gain: random valid/ready traffic,
// register settings changed between phases, and an in-bench predictor of each result.
// Depends on aecg_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import aecg_pkg::*;

  // Indexes that map to no register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int FRAMES_PER_PHASE = 60;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [7:0]  contrast;
    logic [15:0] bright;
    logic [31:0] sum_one;
    logic [31:0] sum_two;
  } frame_t;

  typedef struct packed {
    logic [17:0] red;
    logic [17:0] green;
    logic [17:0] blue;
    logic [23:0] offset;
    logic [6:0]  gain_one;
    logic [6:0]  gain_two;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] red_gain = '0;
  logic [15:0] green_gain = '0;
  logic [15:0] blue_gain = '0;
  logic [7:0]  contrast_level = '0;
  logic [15:0] brightness_level = '0;
  logic [31:0] pixel_sum_one = '0;
  logic [31:0] pixel_sum_two = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [17:0]        red_constant;
  logic [17:0]        green_constant;
  logic [17:0]        blue_constant;
  logic signed [23:0] offset_constant;
  logic [6:0]         sensor_gain_one;
  logic [6:0]         sensor_gain_two;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Register and gain copies used for prediction
  logic [31:0] model_divisor;
  logic [9:0]  model_target;
  logic [7:0]  model_hyst;
  logic [6:0]  model_floor;
  logic [6:0]  model_ceiling;
  logic [6:0]  model_gain_one;
  logic [6:0]  model_gain_two;

  frame_t  frames_to_send[$];
  result_t pending_results[$];
  frame_t  next_frame;
  frame_t  seen_frame;
  result_t want;

  bit idle_on = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int err_count = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_settings = 1;

  auto_exposure_contrast_gain u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .red_gain         (red_gain),
    .green_gain       (green_gain),
    .blue_gain        (blue_gain),
    .contrast_level   (contrast_level),
    .brightness_level (brightness_level),
    .pixel_sum_one    (pixel_sum_one),
    .pixel_sum_two    (pixel_sum_two),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .red_constant     (red_constant),
    .green_constant   (green_constant),
    .blue_constant    (blue_constant),
    .offset_constant  (offset_constant),
    .sensor_gain_one  (sensor_gain_one),
    .sensor_gain_two  (sensor_gain_two),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Step one camera gain against the dead band, then clamp floor first
  function automatic logic [6:0] next_gain(logic [6:0] gain, logic [31:0] avg);
    longint lo, hi, a, t, h;
    int g, fl, ce;
    t = model_target;
    h = model_hyst;
    a = avg;
    lo = t - h;
    hi = t + h;
    g = gain;
    fl = model_floor;
    ce = model_ceiling;
    if (a < lo) g = g + 1;
    else if (a > hi) g = g - 1;
    if (g < fl) g = fl;
    else if (g >= ce) g = ce;
    return g[6:0];
  endfunction

  // Work out the color, offset and gain words for one frame; advance gain state
  function automatic result_t compute_frame_result(frame_t f);
    int unsigned c, scale, d9;
    int term, off;
    logic [31:0] avg_one, avg_two;
    result_t r;
    c = f.contrast;
    scale = ((325 * (c + 128)) / (387 - c)) >> 5;
    r.red = 18'((f.red * scale) / 10);
    r.green = 18'((f.green * scale) / 10);
    r.blue = 18'((f.blue * scale) / 10);
    term = (128 * scale) / 10;
    off = 128 * (int'(f.bright) - term);
    r.offset = off[23:0];
    // A zero divisor yields an all-ones average
    avg_one = (model_divisor == 0) ? 32'hFFFF_FFFF : f.sum_one / model_divisor;
    d9 = model_divisor / 9;
    avg_two = (d9 == 0) ? 32'hFFFF_FFFF : f.sum_two / d9;
    model_gain_one = next_gain(model_gain_one, avg_one);
    model_gain_two = next_gain(model_gain_two, avg_two);
    r.gain_one = model_gain_one;
    r.gain_two = model_gain_two;
    return r;
  endfunction

  // Pixel sum whose average mostly lands near the dead band
  function automatic logic [31:0] pick_sum(logic [31:0] div, int t, int h);
    int unsigned r;
    longint lvl, d, v;
    r = $urandom_range(0, 99);
    if (r < 75 && div != 0) begin
      d = div;
      lvl = t - h - 3 + longint'($urandom_range(0, 2 * h + 6));
      if (lvl < 0) lvl = 0;
      v = lvl * d + longint'($urandom_range(0, div - 1));
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      return v[31:0];
    end
    if (r < 88) return $urandom;
    if (r < 94) return 32'd0;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [15:0] pick_word16();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic add_frame(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [7:0] c,
                           logic [15:0] br, logic [31:0] s1, logic [31:0] s2);
    frames_to_send.push_back({r, g, b, c, br, s1, s2});
    n_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  // Hold until every queued word is taken and every result has come back
  task automatic wait_drained();
    while (n_accepted != n_queued || pending_results.size() != 0) @(posedge clk);
  endtask

  // Input driver: present the next word, keep it until taken, then idle a while
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (frames_to_send.size() > 0) begin
        next_frame = frames_to_send.pop_front();
        in_valid         <= 1'b1;
        red_gain         <= next_frame.red;
        green_gain       <= next_frame.green;
        blue_gain        <= next_frame.blue;
        contrast_level   <= next_frame.contrast;
        brightness_level <= next_frame.bright;
        pixel_sum_one    <= next_frame.sum_one;
        pixel_sum_two    <= next_frame.sum_two;
        send_gap         <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall out_ready at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left <= pick_gap();
    end
  end

  // Track register writes and predict each accepted word
  always @(posedge clk) begin
    if (rst) begin
      model_divisor  = FRAME_DIVISOR_RESET;
      model_target   = TARGET_AVERAGE_RESET;
      model_hyst     = HYSTERESIS_BAND_RESET;
      model_floor    = GAIN_FLOOR_RESET;
      model_ceiling  = GAIN_CEILING_RESET;
      model_gain_one = GAIN_RESET;
      model_gain_two = GAIN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_DIVISOR:   model_divisor = cfg_data;
          REG_TARGET_AVERAGE:  model_target  = cfg_data[9:0];
          REG_HYSTERESIS_BAND: model_hyst    = cfg_data[7:0];
          REG_GAIN_FLOOR:      model_floor   = cfg_data[6:0];
          REG_GAIN_CEILING:    model_ceiling = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        seen_frame = {red_gain, green_gain, blue_gain, contrast_level, brightness_level,
                      pixel_sum_one, pixel_sum_two};
        pending_results.push_back(compute_frame_result(seen_frame));
        n_accepted++;
      end
    end
  end

  task automatic check_field(string name, logic signed [31:0] want_v,
                             logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        check_field("red_constant", want.red, red_constant);
        check_field("green_constant", want.green, green_constant);
        check_field("blue_constant", want.blue, blue_constant);
        check_field("offset_constant", $signed(want.offset), offset_constant);
        check_field("sensor_gain_one", want.gain_one, sensor_gain_one);
        check_field("sensor_gain_two", want.gain_two, sensor_gain_two);
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [31:0] div;
    int t, h, fl, ce, a, b, sel, n_frames;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: field extremes and both edges of the dead band
    add_frame(16'h0000, 16'h0000, 16'h0000, 8'd0, 16'h0000, 32'd0, 32'd0);
    add_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_frame(16'd1234, 16'd4321, 16'd999, 8'd128, 16'h0000, 32'd398131200, 32'd48384000);
    add_frame(16'hFFFF, 16'h0000, 16'hFFFF, 8'd255, 16'h0000, 32'd393984000, 32'd47923200);
    add_frame(16'h0000, 16'hFFFF, 16'h0000, 8'd0, 16'hFFFF, 32'd431308800, 32'd43776000);
    add_frame(16'h5555, 16'hAAAA, 16'h8001, 8'd1, 16'h8000, 32'd435456000, 32'd44236800);
    add_frame(16'hAAAA, 16'h5555, 16'h7FFE, 8'd254, 16'h7FFF, 32'h5555_5555, 32'hAAAA_AAAA);
    add_frame(16'h0001, 16'h8000, 16'h00FF, 8'd127, 16'd1, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();

    // Zero divisor; ceiling at zero, then a step below zero held at the floor
    write_reg(REG_FRAME_DIVISOR, 32'd0);
    write_reg(REG_TARGET_AVERAGE, 32'hFFFF_FFFF);
    write_reg(REG_HYSTERESIS_BAND, 32'd255);
    write_reg(REG_GAIN_FLOOR, 32'd0);
    write_reg(REG_GAIN_CEILING, 32'd0);
    n_settings++;
    add_frame(16'd100, 16'd200, 16'd300, 8'd64, 16'd500, 32'd0, 32'd0);
    add_frame(16'd7, 16'd8, 16'd9, 8'd200, 16'd50, 32'd12345, 32'd678);
    add_frame(16'd1, 16'd2, 16'd3, 8'd32, 16'd0, 32'hFFFF_FFFF, 32'd0);
    wait_drained();

    // Negative lower threshold, divisor below nine, unmapped indexes dropped
    write_reg(REG_FRAME_DIVISOR, 32'd5);
    write_reg(REG_TARGET_AVERAGE, 32'hFFFF_FC00);
    write_reg(REG_GAIN_FLOOR, 32'hFFFF_FF7F);
    write_reg(REG_GAIN_CEILING, 32'd127);
    write_reg(REG_UNMAPPED_LO, 32'd0);
    write_reg(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
    n_settings++;
    add_frame(16'd11, 16'd22, 16'd33, 8'd96, 16'd1000, 32'd0, 32'd0);
    add_frame(16'd44, 16'd55, 16'd66, 8'd160, 16'd2000, 32'd1279, 32'd99);
    wait_drained();

    // Step up from the top gain: stepped value of 128 clamps to the ceiling
    write_reg(REG_TARGET_AVERAGE, 32'd1023);
    write_reg(REG_HYSTERESIS_BAND, 32'hFFFF_FF00);
    n_settings++;
    add_frame(16'd3, 16'd6, 16'd9, 8'd10, 16'd3000, 32'd0, 32'd0);
    add_frame(16'd12, 16'd15, 16'd18, 8'd250, 16'd4000, 32'd0, 32'd7);
    wait_drained();

    // Floor above ceiling: the floor test wins, then the ceiling test
    write_reg(REG_FRAME_DIVISOR, 32'd9);
    write_reg(REG_TARGET_AVERAGE, 32'd500);
    write_reg(REG_HYSTERESIS_BAND, 32'd10);
    write_reg(REG_GAIN_FLOOR, 32'd100);
    write_reg(REG_GAIN_CEILING, 32'd20);
    n_settings++;
    for (int i = 0; i < 4; i++)
      add_frame(pick_word16(), pick_word16(), pick_word16(), 8'(i * 80), 16'(i), 32'd0, 32'd0);
    wait_drained();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph != 1);
      sel = $urandom_range(0, 9);
      case (sel)
        0: div = 32'd0;
        1: div = $urandom_range(1, 8);
        2: div = 32'd9;
        3: div = 32'hFFFF_FFFF;
        4: div = $urandom;
        default: div = $urandom_range(1000, 8000000);
      endcase
      sel = $urandom_range(0, 5);
      t = (sel == 0) ? 0 : (sel == 1) ? 1023 : $urandom_range(0, 1023);
      sel = $urandom_range(0, 5);
      h = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 24);
      a = $urandom_range(0, 127);
      b = $urandom_range(0, 127);
      sel = $urandom_range(0, 7);
      if (sel == 0) begin
        fl = 0;
        ce = 127;
      end else if (sel == 1) begin
        fl = (a > b) ? a : b;
        ce = (a > b) ? b : a;
      end else begin
        fl = (a > b) ? b : a;
        ce = (a > b) ? a : b;
      end
      // Upper data bits are random; the block keeps only the register width
      write_reg(REG_FRAME_DIVISOR, div);
      write_reg(REG_TARGET_AVERAGE, ($urandom & ~32'h3FF) | 32'(t));
      write_reg(REG_HYSTERESIS_BAND, ($urandom & ~32'hFF) | 32'(h));
      write_reg(REG_GAIN_FLOOR, ($urandom & ~32'h7F) | 32'(fl));
      write_reg(REG_GAIN_CEILING, ($urandom & ~32'h7F) | 32'(ce));
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), $urandom);
      n_settings++;

      for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
        // Halfway through one phase, let the sender wait until all results are in
        if (ph == 4 && i == FRAMES_PER_PHASE / 2) wait_drained();
        add_frame(pick_word16(), pick_word16(), pick_word16(), 8'($urandom_range(0, 255)),
                  pick_word16(), pick_sum(div, t, h), pick_sum(div / 9, t, h));
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    n_frames = n_accepted;
    $display("Summary: %0d frames checked under %0d register settings (%0d writes),",
             n_frames, n_settings, n_writes);
    $display("  with random gaps and output stalls in all but the directed and one phase");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
